[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pid_aw_pkg.sv]
// ----------------------------------------------------------------------------
// pid_aw_pkg
// Widths, register indexes and reset values for the anti-windup PID block.
// ----------------------------------------------------------------------------
package pid_aw_pkg;

    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_GAIN_FRAC_BITS = 8;

    localparam int GAIN_W  = 16;
    localparam int ILIM_W  = 20;
    localparam int OLIM_W  = 15;
    localparam int DRIVE_W = OLIM_W + 1;
    localparam int SUM_W   = 22;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = ILIM_W;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_KP         = 3'd0;
    localparam cfg_addr_t REG_KI         = 3'd1;
    localparam cfg_addr_t REG_KD         = 3'd2;
    localparam cfg_addr_t REG_INT_LIMIT  = 3'd3;
    localparam cfg_addr_t REG_OUT_LIMIT  = 3'd4;
    localparam cfg_addr_t REG_ANGLE_WRAP = 3'd5;

    localparam logic [ILIM_W-1:0] INT_LIMIT_RST = ILIM_W'(3000);
    localparam logic [OLIM_W-1:0] OUT_LIMIT_RST = OLIM_W'(3000);

    // Angle wrap: half turn and full turn in degrees
    localparam int WRAP_HALF = 180;
    localparam int WRAP_FULL = 360;

endpackage

[rtl/pid_controller_antiwindup_top.sv]
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_top
// PID control step with clamped integral and conditional integration.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  s_        in         s_valid / s_ready, s_setpoint, s_measured
//  m_        out        m_valid / m_ready, m_drive
//  cfg_      in         cfg_valid / cfg_ready, cfg_addr, cfg_data
//
//  One item per cycle sustained while m_ready is high; the path is the input
//  register, then the error/integral/product logic into the result register.
//  The integral and last error update in the cycle the item moves into the
//  result register, so consecutive items see each other's state.
//  Synchronous active-low reset; cfg_ready is always high.
//  A stalled m_ready holds the result; one more item waits in the input reg.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_top
    import pid_aw_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_setpoint,
    input  logic signed [SAMPLE_WIDTH-1:0] s_measured,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [DRIVE_W-1:0]      m_drive,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    localparam int E_W    = SAMPLE_WIDTH + 1;
    localparam int XW     = ((E_W > 10) ? E_W : 10) + 1;
    localparam int D_W    = E_W + 1;
    localparam int CAND_W = ((SUM_W > E_W) ? SUM_W : E_W) + 1;
    localparam int ACC_W  = GAIN_W + CAND_W + 2;

    // configuration
    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [ILIM_W-1:0]        int_limit_reg;
    logic [OLIM_W-1:0]        out_limit_reg;
    logic                     angle_wrap_reg;

    // pipeline and loop state
    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sp_reg, ms_reg;
    logic                           out_valid_reg;
    logic signed [DRIVE_W-1:0]      drive_reg, drive_next;
    logic signed [SUM_W-1:0]        error_sum_reg, error_sum_next;
    logic signed [E_W-1:0]          prev_err_reg;

    logic advance;

    logic signed [XW-1:0]     e_raw, e_hi, e_lo;
    logic signed [E_W-1:0]    err;
    logic signed [D_W-1:0]    deriv;
    logic signed [CAND_W-1:0] cand_raw, lim_pos, lim_neg;
    logic signed [SUM_W-1:0]  cand;
    logic signed [ACC_W-1:0]  p_kp, p_ki_cand, p_ki_sum, p_kd;
    logic signed [ACC_W-1:0]  tent, held, drv_acc, olim_pos, olim_neg;
    logic                     err_pos, err_neg, hold_sum;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_drive   = drive_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        // error with optional single wrap into +/-180
        e_raw = XW'(sp_reg) - XW'(ms_reg);
        e_hi  = (angle_wrap_reg && e_raw > XW'(WRAP_HALF)) ? e_raw - XW'(WRAP_FULL) : e_raw;
        e_lo  = (angle_wrap_reg && e_hi < -XW'(WRAP_HALF)) ? e_hi + XW'(WRAP_FULL) : e_hi;
        err   = e_lo[E_W-1:0];
        err_neg = err[E_W-1];
        err_pos = !err[E_W-1] && (err != '0);

        deriv = D_W'(err) - D_W'(prev_err_reg);

        // candidate integral, clamped
        cand_raw = CAND_W'(error_sum_reg) + CAND_W'(err);
        lim_pos  = CAND_W'(signed'({1'b0, int_limit_reg}));
        lim_neg  = -lim_pos;
        if (cand_raw > lim_pos) begin
            cand = lim_pos[SUM_W-1:0];
        end else if (cand_raw < lim_neg) begin
            cand = lim_neg[SUM_W-1:0];
        end else begin
            cand = cand_raw[SUM_W-1:0];
        end

        p_kp      = ACC_W'(kp_reg) * ACC_W'(err);
        p_ki_cand = ACC_W'(ki_reg) * ACC_W'(cand);
        p_ki_sum  = ACC_W'(ki_reg) * ACC_W'(error_sum_reg);
        p_kd      = ACC_W'(kd_reg) * ACC_W'(deriv);

        tent = (p_kp + p_ki_cand + p_kd) >>> GAIN_FRAC_BITS;
        held = (p_kp + p_ki_sum + p_kd) >>> GAIN_FRAC_BITS;

        olim_pos = ACC_W'(signed'({1'b0, out_limit_reg}));
        olim_neg = -olim_pos;

        // integration stops while the output is pinned in the error's direction
        hold_sum = (tent > olim_pos && err_pos) || (tent < olim_neg && err_neg);
        error_sum_next = hold_sum ? error_sum_reg : cand;
        drv_acc        = hold_sum ? held : tent;

        if (drv_acc > olim_pos) begin
            drive_next = olim_pos[DRIVE_W-1:0];
        end else if (drv_acc < olim_neg) begin
            drive_next = olim_neg[DRIVE_W-1:0];
        end else begin
            drive_next = drv_acc[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            error_sum_reg  <= '0;
            prev_err_reg   <= '0;
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            int_limit_reg  <= INT_LIMIT_RST;
            out_limit_reg  <= OUT_LIMIT_RST;
            angle_wrap_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                error_sum_reg <= error_sum_next;
                prev_err_reg  <= err;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                unique case (cfg_addr)
                    REG_KP:         kp_reg         <= cfg_data[GAIN_W-1:0];
                    REG_KI:         ki_reg         <= cfg_data[GAIN_W-1:0];
                    REG_KD:         kd_reg         <= cfg_data[GAIN_W-1:0];
                    REG_INT_LIMIT:  int_limit_reg  <= cfg_data[ILIM_W-1:0];
                    REG_OUT_LIMIT:  out_limit_reg  <= cfg_data[OLIM_W-1:0];
                    REG_ANGLE_WRAP: angle_wrap_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sp_reg <= s_setpoint;
            ms_reg <= s_measured;
        end
        if (advance) begin
            drive_reg <= drive_next;
        end
    end

endmodule

[rtl/pid_aw_checker.sv]
// ----------------------------------------------------------------------------
// pid_aw_checker
// Port-level checks for the PID block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_aw_checker
    import pid_aw_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [DRIVE_W-1:0] m_drive,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    // no result can come out of reset
    `ASSERT_CLK_NORST(a_no_result_after_reset, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // saturation never reaches the most negative code
    `ASSERT_CLK(a_drive_range, aclk, aresetn, m_valid |-> !(m_drive[DRIVE_W-1] && m_drive[DRIVE_W-2:0] == '0), "drive out of range")

    // with the result side open, input never stalls
    `ASSERT_CLK(a_no_input_stall, aclk, aresetn, (s_valid && m_ready) |-> s_ready, "input stalled with output open")

    // a transfer on the result side is held until taken
    `ASSERT_CLK(a_result_held, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_drive)), "stalled result changed")

    // register writes are never refused
    `ASSERT_CLK(a_cfg_ready, aclk, aresetn, cfg_valid |-> cfg_ready, "config write stalled")

endmodule

bind pid_controller_antiwindup_top pid_aw_checker u_pid_aw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_drive   (m_drive),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

[verif/tb_pid_controller_antiwindup_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_antiwindup_top
// Self-checking bench for the anti-windup PID step: bursty input transfers,
// a receiver that stalls on its own pace, gain and limit sets loaded between
// phases, and every drive compared against a cycle-free model of the loop.
// ----------------------------------------------------------------------------
module tb_pid_controller_antiwindup_top;
    import pid_aw_pkg::*;

    localparam int SW        = DEF_SAMPLE_WIDTH;
    localparam int GAIN_FRAC = DEF_GAIN_FRAC_BITS;

    // Indexes past the register list; the block drops these writes
    localparam cfg_addr_t REG_SPARE_LO = 3'd6;
    localparam cfg_addr_t REG_SPARE_HI = 3'd7;

    localparam int HOLD_CYCLES = 400;

    typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_BEAT} rx_pace_e;

    // ------------------------------------------------------------------------
    // Loop model: own copy of the gains, limits, error sum and last error
    // ------------------------------------------------------------------------
    class drive_predictor;
        logic signed [GAIN_W-1:0]  kp_gain = '0;
        logic signed [GAIN_W-1:0]  ki_gain = '0;
        logic signed [GAIN_W-1:0]  kd_gain = '0;
        logic [ILIM_W-1:0]         int_limit = INT_LIMIT_RST;
        logic [OLIM_W-1:0]         out_limit = OUT_LIMIT_RST;
        bit                        wrap_on = 1'b0;
        logic signed [SUM_W-1:0]   error_sum = '0;
        logic signed [SW:0]        prior_error = '0;
        logic signed [DRIVE_W-1:0] pending_drive[$];
        int                        mismatches = 0;
        int                        drives_checked = 0;

        function void write_reg(cfg_addr_t addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_KP:         kp_gain = data[GAIN_W-1:0];
                REG_KI:         ki_gain = data[GAIN_W-1:0];
                REG_KD:         kd_gain = data[GAIN_W-1:0];
                REG_INT_LIMIT:  int_limit = data[ILIM_W-1:0];
                REG_OUT_LIMIT:  out_limit = data[OLIM_W-1:0];
                REG_ANGLE_WRAP: wrap_on = data[0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [SW-1:0] sp, logic signed [SW-1:0] ms);
            longint err, slope, cand, tent, drv, lim_i, lim_o;
            err = longint'(sp) - longint'(ms);
            if (wrap_on) begin
                if (err > WRAP_HALF) err -= WRAP_FULL;
                if (err < -WRAP_HALF) err += WRAP_FULL;
            end
            slope = err - longint'(prior_error);
            lim_i = longint'(int_limit);
            lim_o = longint'(out_limit);
            cand = longint'(error_sum) + err;
            if (cand > lim_i) cand = lim_i;
            else if (cand < -lim_i) cand = -lim_i;
            tent = (longint'(kp_gain) * err + longint'(ki_gain) * cand
                    + longint'(kd_gain) * slope) >>> GAIN_FRAC;
            // conditional integration: hold the sum while saturated in the error's direction
            if (!((tent > lim_o && err > 0) || (tent < -lim_o && err < 0)))
                error_sum = cand[SUM_W-1:0];
            drv = (longint'(kp_gain) * err + longint'(ki_gain) * longint'(error_sum)
                   + longint'(kd_gain) * slope) >>> GAIN_FRAC;
            if (drv > lim_o) drv = lim_o;
            else if (drv < -lim_o) drv = -lim_o;
            prior_error = err[SW:0];
            pending_drive.push_back(drv[DRIVE_W-1:0]);
        endfunction

        function void compare_drive(logic signed [DRIVE_W-1:0] got);
            logic signed [DRIVE_W-1:0] want;
            drives_checked++;
            if (pending_drive.size() == 0) begin
                $error("drive: no result expected, actual %0d", got);
                mismatches++;
            end else begin
                want = pending_drive.pop_front();
                if (got !== want) begin
                    $error("drive: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [SW-1:0]      s_setpoint;
    logic signed [SW-1:0]      s_measured;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [DRIVE_W-1:0] m_drive;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [CFG_DATA_W-1:0]     cfg_data;

    drive_predictor pred = new();

    int burst_left = 8;
    int hold_requests = 0;
    int steps_sent = 0;
    int config_loads = 0;

    always #5 aclk = ~aclk;

    pid_controller_antiwindup_top u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_setpoint (s_setpoint),
        .s_measured (s_measured),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data)
    );

    // Result side: pace is redrawn whenever its span runs out; long hold on request
    initial begin
        rx_pace_e pace;
        int       pace_left;
        int       holds_done;
        int       beat;
        pace = RX_FREE;
        pace_left = 0;
        holds_done = 0;
        beat = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            beat++;
            if (holds_done != hold_requests) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (pace_left == 0) begin
                    pace = rx_pace_e'($urandom_range(0, 3));
                    pace_left = $urandom_range(16, 96);
                end
                pace_left--;
                case (pace)
                    RX_FREE:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                    RX_BEAT:   m_ready <= (beat % 3 == 0);
                    default:   m_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pred.compare_drive(m_drive);
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One control step; valid stays up across a burst
    task automatic send_step(input logic signed [SW-1:0] sp, input logic signed [SW-1:0] ms);
        s_valid <= 1'b1;
        s_setpoint <= sp;
        s_measured <= ms;
        do @(posedge aclk); while (!s_ready);
        pred.take_sample(sp, ms);
        steps_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Writes the selected registers back to back, plus an optional stray index
    task automatic load_settings(input bit [5:0] which,
                                 input logic [CFG_DATA_W-1:0] kp_v, ki_v, kd_v,
                                 input logic [CFG_DATA_W-1:0] ilim_v, olim_v, wrap_v,
                                 input bit stray);
        cfg_addr_t               idx[7];
        logic [CFG_DATA_W-1:0]   val[7];
        idx[0] = REG_KP;         val[0] = kp_v;
        idx[1] = REG_KI;         val[1] = ki_v;
        idx[2] = REG_KD;         val[2] = kd_v;
        idx[3] = REG_INT_LIMIT;  val[3] = ilim_v;
        idx[4] = REG_OUT_LIMIT;  val[4] = olim_v;
        idx[5] = REG_ANGLE_WRAP; val[5] = wrap_v;
        idx[6] = $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
        val[6] = CFG_DATA_W'($urandom);
        for (int i = 0; i < 7; i++) begin
            if ((i < 6 && which[i]) || (i == 6 && stray)) begin
                cfg_valid <= 1'b1;
                cfg_addr <= idx[i];
                cfg_data <= val[i];
                do @(posedge aclk); while (!cfg_ready);
                pred.write_reg(idx[i], val[i]);
            end
        end
        cfg_valid <= 1'b0;
        config_loads++;
    endtask

    // Stop offering, wait out all drives and the pipeline
    task automatic drain();
        s_valid <= 1'b0;
        while (pred.pending_drive.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int                       dice;
        logic signed [GAIN_W-1:0] g;
        dice = $urandom_range(0, 3);
        if (dice == 0)
            g = GAIN_W'($urandom);
        else if (dice == 1)
            g = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else
            g = GAIN_W'(int'($urandom_range(0, 1536)) - 768);
        return {4'($urandom), g};
    endfunction

    task automatic random_steps(input int count, input bit with_hold);
        int                   dice;
        int                   base;
        logic signed [SW-1:0] sp;
        logic signed [SW-1:0] ms;
        for (int k = 0; k < count; k++) begin
            if (with_hold && k == count / 3) begin
                // receiver goes quiet; keep offering so the input side backs up
                hold_requests <= hold_requests + 1;
                burst_left = count;
            end
            dice = $urandom_range(0, 9);
            if (dice < 3) begin
                sp = SW'($urandom);
                ms = SW'($urandom);
            end else if (dice < 7) begin
                base = int'($urandom_range(0, 4000)) - 2000;
                sp = SW'(base);
                ms = SW'(base + int'($urandom_range(0, 600)) - 300);
            end else begin
                sp = SW'(int'($urandom_range(0, 720)) - 360);
                ms = SW'(int'($urandom_range(0, 720)) - 360);
            end
            send_step(sp, ms);
        end
    endtask

    initial begin
        int                    dice;
        logic [CFG_DATA_W-1:0] ilim_v;
        logic [OLIM_W-1:0]     olim_v;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_setpoint = '0;
        s_measured = '0;
        cfg_valid = 1'b0;
        cfg_addr = REG_KP;
        cfg_data = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // First step with only kp/kd set: derivative sees the whole error,
        // limits still at their reset values
        load_settings(6'b000101, CFG_DATA_W'(256), '0, CFG_DATA_W'(128), '0, '0, '0, 1'b0);
        send_step(16'sd1000, 16'sd0);
        send_step(16'sd4000, 16'sd0);
        send_step(-16'sd32768, 16'sd32767);
        drain();

        load_settings(6'b111111, CFG_DATA_W'(256), CFG_DATA_W'(32), CFG_DATA_W'(64),
                      CFG_DATA_W'(3000), CFG_DATA_W'(3000), '0, 1'b1);
        send_step(16'sd32767, -16'sd32768);
        send_step(16'sd0, 16'sd0);
        send_step(16'sd50, 16'sd20);
        send_step(16'sd50, 16'sd20);
        send_step(-16'sd10, 16'sd5);
        drain();

        // Angle wrap around the half-turn points, then a huge error wrapped once
        load_settings(6'b111111, CFG_DATA_W'(256), '0, '0, CFG_DATA_W'(3000),
                      CFG_DATA_W'(32767), CFG_DATA_W'(1), 1'b0);
        send_step(16'sd200, 16'sd0);
        send_step(16'sd0, 16'sd200);
        send_step(16'sd180, 16'sd0);
        send_step(-16'sd180, 16'sd0);
        send_step(16'sd181, 16'sd0);
        send_step(16'sd0, 16'sd181);
        send_step(16'sd32767, -16'sd32768);
        send_step(-16'sd32768, 16'sd32767);
        drain();

        // Zero limits: sum pinned at zero, drive forced to zero
        load_settings(6'b111111, CFG_DATA_W'(16'sh7FFF), CFG_DATA_W'(16'sh7FFF),
                      CFG_DATA_W'(16'sh8000), '0, '0, '0, 1'b0);
        send_step(16'sd1000, 16'sd0);
        send_step(-16'sd1000, 16'sd0);
        send_step(16'sd5, -16'sd5);
        drain();

        // Heavy ki with a tight output limit: integration stops while saturated
        load_settings(6'b111111, CFG_DATA_W'(256), CFG_DATA_W'(16384), '0,
                      CFG_DATA_W'(20'hFFFFF), CFG_DATA_W'(500), '0, 1'b0);
        send_step(16'sd100, 16'sd0);
        send_step(16'sd100, 16'sd0);
        send_step(16'sd100, 16'sd0);
        send_step(-16'sd100, 16'sd0);
        send_step(-16'sd100, 16'sd0);
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                load_settings(6'b111111, CFG_DATA_W'(16'sh8000), CFG_DATA_W'(16'sh7FFF),
                              CFG_DATA_W'(16'sh8000), CFG_DATA_W'(20'hFFFFF),
                              CFG_DATA_W'(15'h7FFF), '0, 1'b0);
            end else if (p == 1) begin
                load_settings(6'b111111, CFG_DATA_W'(16'sh7FFF), CFG_DATA_W'(16'sh8000),
                              CFG_DATA_W'(16'sh7FFF), CFG_DATA_W'(20'hFFFFF),
                              CFG_DATA_W'(15'h7FFF), CFG_DATA_W'(1), 1'b1);
            end else begin
                dice = $urandom_range(0, 3);
                if (dice == 0) ilim_v = '0;
                else if (dice == 1) ilim_v = 20'hFFFFF;
                else if (dice == 2) ilim_v = CFG_DATA_W'($urandom_range(1, 4000));
                else ilim_v = CFG_DATA_W'($urandom);
                dice = $urandom_range(0, 3);
                if (dice == 0) olim_v = '0;
                else if (dice == 1) olim_v = 15'h7FFF;
                else if (dice == 2) olim_v = OLIM_W'($urandom_range(1, 3000));
                else olim_v = OLIM_W'($urandom);
                load_settings(6'b111111, pick_gain(), pick_gain(), pick_gain(), ilim_v,
                              {5'($urandom), olim_v}, {19'($urandom), 1'($urandom)},
                              1'($urandom));
            end
            random_steps(106, (p == 3 || p == 6));
            drain();
        end

        repeat (10) @(posedge aclk);
        if (pred.pending_drive.size() != 0) begin
            $error("drive: %0d results never arrived", pred.pending_drive.size());
            pred.mismatches++;
        end
        $display("Covered %0d control steps across %0d register loads,", steps_sent,
                 config_loads);
        $display("%0d drive results checked, including angle wrap, zero limits and windup hold.",
                 pred.drives_checked);
        if (pred.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
